/* design/smbus_pec_temp_frame_checker_top_assert.svh */
// ----------------------------------------------------------------------------
// SMBus PEC frame checker: assertion macros
// Shared concurrent assertion wrappers clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SMBUS_PEC_TEMP_FRAME_CHECKER_TOP_ASSERT_SVH
`define SMBUS_PEC_TEMP_FRAME_CHECKER_TOP_ASSERT_SVH

// Property checked only while the block is out of reset.
`define SMBPEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SMBPEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/smbpec_pkg.sv */
// ----------------------------------------------------------------------------
// SMBus PEC frame checker package
// Types, constants and the CRC-8 helper shared by the checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smbpec_pkg;

  // Number of sensors with a slot of their own; one more default slot follows.
  localparam int DIRECT_SENSORS = 3;
  localparam int SLOT_COUNT     = DIRECT_SENSORS + 1;
  localparam int SLOT_W         = $clog2(SLOT_COUNT);
  localparam int COUNTER_WIDTH  = 16;
  localparam int STREAK_W       = 8;
  localparam int TEMP_W         = 18;
  localparam int ADDR_W         = 7;

  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [7:0] READ_CMD_RESET = 8'h07;

  // 273.15 K expressed in hundredths of a degree.
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 18'sd27315;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_READ_COMMAND = 1'b0
  } reg_idx_e;

  // One received read-word response.
  typedef struct packed {
    logic [7:0]        pec;
    logic [7:0]        data_high;
    logic [7:0]        data_low;
    logic              nack;
    logic [ADDR_W-1:0] sensor_address;
  } item_t;

  // Outcome of the frame check, handed to the slot update.
  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic                     nack;
    logic                     crc_ok;
    logic signed [TEMP_W-1:0] temperature;
  } check_t;

  // One result item.
  typedef struct packed {
    logic [STREAK_W-1:0]      fail_streak;
    logic [COUNTER_WIDTH-1:0] nack_error_total;
    logic [COUNTER_WIDTH-1:0] pec_error_total;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic                     frame_ok;
    logic [SLOT_W-1:0]        slot;
  } result_t;

  // SMBus CRC-8 over one byte, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* design/smbpec_frame.sv */
// ----------------------------------------------------------------------------
// SMBus PEC frame check
// Maps the address to a slot, computes the PEC of the read-word transaction
// and converts the raw reading to hundredths of a degree Celsius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbpec_frame (
  input  smbpec_pkg::item_t  item_i,
  input  logic [7:0]         read_command_i,
  output smbpec_pkg::check_t check_o
);

  logic [7:0]  addr_wr;
  logic [7:0]  addr_rd;
  logic [7:0]  crc;
  logic        direct;
  logic [15:0] raw;

  // Addresses 1 up to the number of direct sensors own a slot each.
  assign direct = (item_i.sensor_address != '0) &&
                  (item_i.sensor_address <= smbpec_pkg::ADDR_W'(smbpec_pkg::DIRECT_SENSORS));

  assign check_o.slot = direct ?
      smbpec_pkg::SLOT_W'(item_i.sensor_address - smbpec_pkg::ADDR_W'(1)) :
      smbpec_pkg::SLOT_W'(smbpec_pkg::DIRECT_SENSORS);

  // PEC covers write address, command, read address and both data bytes.
  assign addr_wr = {item_i.sensor_address, 1'b0};
  assign addr_rd = {item_i.sensor_address, 1'b1};

  always_comb begin
    crc = 8'h00;
    crc = smbpec_pkg::crc8_byte(crc, addr_wr);
    crc = smbpec_pkg::crc8_byte(crc, read_command_i);
    crc = smbpec_pkg::crc8_byte(crc, addr_rd);
    crc = smbpec_pkg::crc8_byte(crc, item_i.data_low);
    crc = smbpec_pkg::crc8_byte(crc, item_i.data_high);
  end

  assign check_o.nack   = item_i.nack;
  assign check_o.crc_ok = (crc == item_i.pec);

  // Raw is in units of 0.02 K, so twice raw is hundredths of a kelvin.
  assign raw = {item_i.data_high, item_i.data_low};
  assign check_o.temperature = $signed({1'b0, raw, 1'b0}) - smbpec_pkg::TEMP_OFFSET;

endmodule

/* design/smbpec_slots.sv */
// ----------------------------------------------------------------------------
// SMBus PEC slot state
// Per-slot temperature, saturating error counters and fail streak; updates
// the selected slot and returns its new contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbpec_slots (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                update_i,
  input  smbpec_pkg::check_t  check_i,
  output smbpec_pkg::result_t result_o
);

  logic signed [smbpec_pkg::TEMP_W-1:0] temp_q [smbpec_pkg::SLOT_COUNT];
  logic [smbpec_pkg::COUNTER_WIDTH-1:0] pec_q [smbpec_pkg::SLOT_COUNT];
  logic [smbpec_pkg::COUNTER_WIDTH-1:0] nack_q [smbpec_pkg::SLOT_COUNT];
  logic [smbpec_pkg::STREAK_W-1:0]      streak_q [smbpec_pkg::SLOT_COUNT];

  logic signed [smbpec_pkg::TEMP_W-1:0] temp_d;
  logic [smbpec_pkg::COUNTER_WIDTH-1:0] pec_d;
  logic [smbpec_pkg::COUNTER_WIDTH-1:0] nack_d;
  logic [smbpec_pkg::STREAK_W-1:0]      streak_d;
  logic [smbpec_pkg::COUNTER_WIDTH-1:0] pec_cur;
  logic [smbpec_pkg::COUNTER_WIDTH-1:0] nack_cur;
  logic [smbpec_pkg::STREAK_W-1:0]      streak_cur;
  logic                                 ok;
  logic                                 pec_bad;

  assign pec_cur    = pec_q[check_i.slot];
  assign nack_cur   = nack_q[check_i.slot];
  assign streak_cur = streak_q[check_i.slot];

  assign ok      = !check_i.nack && check_i.crc_ok;
  assign pec_bad = !check_i.nack && !check_i.crc_ok;

  // New contents of the selected slot; all counters stop at full scale.
  always_comb begin
    temp_d   = ok ? check_i.temperature : temp_q[check_i.slot];
    pec_d    = (pec_bad && (pec_cur != '1)) ? pec_cur + 1'b1 : pec_cur;
    nack_d   = (check_i.nack && (nack_cur != '1)) ? nack_cur + 1'b1 : nack_cur;
    if (ok) begin
      streak_d = '0;
    end else if (streak_cur != '1) begin
      streak_d = streak_cur + 1'b1;
    end else begin
      streak_d = streak_cur;
    end
  end

  // Slot registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < smbpec_pkg::SLOT_COUNT; i++) begin
        temp_q[i]   <= '0;
        pec_q[i]    <= '0;
        nack_q[i]   <= '0;
        streak_q[i] <= '0;
      end
    end else if (update_i) begin
      temp_q[check_i.slot]   <= temp_d;
      pec_q[check_i.slot]    <= pec_d;
      nack_q[check_i.slot]   <= nack_d;
      streak_q[check_i.slot] <= streak_d;
    end
  end

  assign result_o.slot              = check_i.slot;
  assign result_o.frame_ok          = ok;
  assign result_o.temperature_centi = temp_d;
  assign result_o.pec_error_total   = pec_d;
  assign result_o.nack_error_total  = nack_d;
  assign result_o.fail_streak       = streak_d;

endmodule

/* design/smbus_pec_temp_frame_checker_top.sv */
// The input register takes an item when it is accepted; the result register
// takes its result when the input register advances. Throughput: one item per
// cycle unless the output stalls; the check and slot update are in the same cycle.
// Reset: rst_ni clears all slot state, the pipeline valid flags, and sets
// read_command to 7. No clearing pass is needed.
// ----------------------------------------------------------------------------
// SMBus PEC temperature frame checker, top level
// Checks read-word responses against their PEC and keeps per-slot status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smbus_pec_temp_frame_checker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] sensor_address, [14:7] data_low, [22:15] data_high, [30:23] pec, [31] zero
  input  logic [31:0] s_axis_tdata,
  // [0] nack
  input  logic        s_axis_tuser,
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] slot, [19:2] temperature_centi, [35:20] pec_error_total,
  // [51:36] nack_error_total, [59:52] fail_streak, [63:60] zero
  output logic [63:0] m_axis_tdata,
  // [0] frame_ok
  output logic        m_axis_tuser
);

  logic [7:0]                 read_command_q;
  logic                       in_valid_q;
  smbpec_pkg::item_t          in_item_q;
  logic                       out_valid_q;
  smbpec_pkg::result_t        out_result_q;
  smbpec_pkg::check_t         check;
  smbpec_pkg::result_t        result_d;
  smbpec_pkg::reg_idx_e       reg_idx;
  logic                       cfg_write;
  logic                       out_free;
  logic                       advance;

  // Configuration register.
  assign pready    = 1'b1;
  assign reg_idx   = smbpec_pkg::reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_command_q <= smbpec_pkg::READ_CMD_RESET;
    end else if (cfg_write && (reg_idx == smbpec_pkg::REG_READ_COMMAND)) begin
      read_command_q <= pwdata[7:0];
    end
  end

  always_comb begin
    case (reg_idx)
      smbpec_pkg::REG_READ_COMMAND: prdata = {24'h000000, read_command_q};
      default:                      prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the result register frees up.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input item register.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.sensor_address <= s_axis_tdata[6:0];
      in_item_q.data_low       <= s_axis_tdata[14:7];
      in_item_q.data_high      <= s_axis_tdata[22:15];
      in_item_q.pec            <= s_axis_tdata[30:23];
      in_item_q.nack           <= s_axis_tuser;
    end
  end

  smbpec_frame u_frame (
    .item_i         (in_item_q),
    .read_command_i (read_command_q),
    .check_o        (check)
  );

  smbpec_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .check_i  (check),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_result_q.frame_ok;
  assign m_axis_tdata  = {4'h0,
                          out_result_q.fail_streak,
                          out_result_q.nack_error_total,
                          out_result_q.pec_error_total,
                          out_result_q.temperature_centi,
                          out_result_q.slot};

`include "smbus_pec_temp_frame_checker_top_assert.svh"

  // A good frame always leaves the slot's fail streak cleared.
  `SMBPEC_ASSERT(a_ok_clears_streak, (out_valid_q && out_result_q.frame_ok) |-> (out_result_q.fail_streak == '0), "good frame with nonzero fail streak")
  // A bad frame always leaves a nonzero fail streak.
  `SMBPEC_ASSERT(a_bad_counts_streak, (out_valid_q && !out_result_q.frame_ok) |-> (out_result_q.fail_streak != '0), "bad frame with zero fail streak")
  // An item that leaves the input register lands in the result register.
  `SMBPEC_ASSERT(a_advance_fills_out, advance |=> out_valid_q, "advanced item lost")
  // Input side only stalls while an item is held in the input register.
  `SMBPEC_ASSERT_ALWAYS(a_stall_has_item, (rst_ni && !s_axis_tready) |-> in_valid_q, "stall without held item")

endmodule
